[rtl/swhsr_pkg.sv]
// ----------------------------------------------------------------------------
// swhsr_pkg
// Shared types and constants for the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
package swhsr_pkg;

  localparam int unsigned CntBits    = 20;
  localparam int unsigned FrameBits  = 40;
  localparam int unsigned BitIdxBits = 6;
  localparam int unsigned DurBits    = 16;
  localparam int unsigned WordBits   = 16;
  localparam int unsigned CfgIdxBits = 2;

  localparam logic [CntBits-1:0]    CntMax     = {CntBits{1'b1}};
  localparam logic [BitIdxBits-1:0] FrameCount = BitIdxBits'(FrameBits);

  // Register reset values
  localparam logic [CntBits-1:0] TimeoutReset  = CntBits'(1000);
  localparam logic [DurBits-1:0] ReleaseReset  = DurBits'(1100);
  localparam logic [DurBits-1:0] StartLowReset = DurBits'(1100);
  localparam logic [DurBits-1:0] SettleReset   = DurBits'(50);

  // Register indexes
  localparam logic [CfgIdxBits-1:0] CfgTimeout  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgRelease  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgStartLow = 2'd2;
  localparam logic [CfgIdxBits-1:0] CfgSettle   = 2'd3;

  // Byte masks used by the frame decode
  localparam logic [7:0] SignMask = 8'h80;
  localparam logic [7:0] MagMask  = 8'h7F;

  typedef struct packed {
    logic                       good;
    logic signed [WordBits-1:0] temperature;
    logic [WordBits-1:0]        humidity;
  } frame_res_t;

endpackage

[rtl/single_wire_humidity_sensor_reader_unit.sv]
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader_unit
// Single-wire temperature/humidity sensor reader, one item per line tick.
// ----------------------------------------------------------------------------
// Each input item is one tick: the sampled data-line level and a start
// command. The block takes one item per clock and returns exactly one result
// item per input item, through a single output register; the sequencer
// state and the result register are updated in the same cycle, so the rate
// is one item per clock as long as the result side keeps up.
// A read releases the line for release_ticks, drives it low for
// start_low_ticks (drive_low high), releases it for settle_ticks, then times
// the response low/high pulses and 40 bit pulse pairs. A bit is 1 when its
// high pulse is longer than its low pulse. A pulse that runs past
// timeout_ticks ends the read at once with read_ok low; a checksum mismatch
// does likewise. temperature and humidity keep the last good read.
// Configuration writes are taken at any edge with cfg_we high and should only
// be made while no read is in progress.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader_unit (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] command, [1] line_level
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
                                 // [3] read_ok, [19:4] temperature,
                                 // [35:20] humidity, rest zero
  // configuration
  input  logic                                cfg_we,
  input  logic [swhsr_pkg::CfgIdxBits-1:0]    cfg_index,
  input  logic [swhsr_pkg::CntBits-1:0]       cfg_data
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_RELEASE, PH_START_LOW, PH_SETTLE,
    PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_LOW, PH_BIT_HIGH
  } phase_t;

  // configuration registers
  logic [swhsr_pkg::CntBits-1:0] timeout_ticks;
  logic [swhsr_pkg::DurBits-1:0] release_ticks;
  logic [swhsr_pkg::DurBits-1:0] start_low_ticks;
  logic [swhsr_pkg::DurBits-1:0] settle_ticks;

  // sequencer state
  phase_t                                 phase, phase_next;
  logic [swhsr_pkg::CntBits-1:0]          tick_counter, tick_counter_next;
  logic [swhsr_pkg::CntBits-1:0]          low_pulse_count, low_pulse_count_next;
  logic [swhsr_pkg::BitIdxBits-1:0]       bit_index, bit_index_next;
  logic [swhsr_pkg::FrameBits-1:0]        frame_bits, frame_bits_next;
  logic                                   last_ok, last_ok_next;
  logic signed [swhsr_pkg::WordBits-1:0]  last_temperature, last_temperature_next;
  logic [swhsr_pkg::WordBits-1:0]         last_humidity, last_humidity_next;
  logic                                   done_next;

  logic                  command, line_level, s_fire, want_level;
  logic                  pulse_over, bit_val;
  logic [swhsr_pkg::DurBits-1:0]    duration;
  logic [swhsr_pkg::CntBits-1:0]    timed_cnt;
  logic [swhsr_pkg::FrameBits-1:0]  shifted_frame;
  logic [swhsr_pkg::BitIdxBits-1:0] idx_inc;
  swhsr_pkg::frame_res_t            frame_res;

  assign command    = s_tdata[0];
  assign line_level = s_tdata[1];
  assign s_tready   = !m_tvalid || m_tready;
  assign s_fire     = s_tvalid && s_tready;

  // frame as it stands once the bit that ends now is shifted in
  assign bit_val       = (tick_counter > low_pulse_count);
  assign shifted_frame = {frame_bits[swhsr_pkg::FrameBits-2:0], bit_val};
  assign idx_inc       = bit_index + 1'b1;

  swhsr_frame_check u_frame_check (
    .frame (shifted_frame),
    .res   (frame_res)
  );

  // timed phases: saturating count, phase ends at duration (at least one tick)
  always_comb begin
    case (phase)
      PH_RELEASE:   duration = release_ticks;
      PH_START_LOW: duration = start_low_ticks;
      default:      duration = settle_ticks;
    endcase
    timed_cnt = (tick_counter != swhsr_pkg::CntMax) ? tick_counter + 1'b1 : tick_counter;
  end

  assign want_level = !(phase == PH_RESP_LOW || phase == PH_BIT_LOW);
  assign pulse_over = (tick_counter >= timeout_ticks) || (tick_counter == swhsr_pkg::CntMax);

  always_comb begin
    phase_next            = phase;
    tick_counter_next     = tick_counter;
    low_pulse_count_next  = low_pulse_count;
    bit_index_next        = bit_index;
    frame_bits_next       = frame_bits;
    last_ok_next          = last_ok;
    last_temperature_next = last_temperature;
    last_humidity_next    = last_humidity;
    done_next             = 1'b0;

    unique case (phase)
      PH_RELEASE, PH_START_LOW, PH_SETTLE: begin
        tick_counter_next = timed_cnt;
        if (timed_cnt >= swhsr_pkg::CntBits'(duration) || timed_cnt == swhsr_pkg::CntMax) begin
          tick_counter_next = '0;
          case (phase)
            PH_RELEASE:   phase_next = PH_START_LOW;
            PH_START_LOW: phase_next = PH_SETTLE;
            default:      phase_next = PH_RESP_LOW;
          endcase
        end
      end
      PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
        if (line_level == want_level) begin
          if (pulse_over) begin
            phase_next        = PH_IDLE;
            tick_counter_next = '0;
            done_next         = 1'b1;
            last_ok_next      = 1'b0;
          end else begin
            tick_counter_next = tick_counter + 1'b1;
          end
        end else begin
          // level changed: the sample that ends this pulse opens the next one
          case (phase)
            PH_RESP_LOW:  phase_next = PH_RESP_HIGH;
            PH_RESP_HIGH: phase_next = PH_BIT_LOW;
            PH_BIT_LOW: begin
              low_pulse_count_next = tick_counter;
              phase_next           = PH_BIT_HIGH;
            end
            default: begin
              frame_bits_next = shifted_frame;
              bit_index_next  = idx_inc;
              phase_next      = PH_BIT_LOW;
            end
          endcase
          if (phase == PH_BIT_HIGH && idx_inc >= swhsr_pkg::FrameCount) begin
            phase_next        = PH_IDLE;
            tick_counter_next = '0;
            done_next         = 1'b1;
            last_ok_next      = frame_res.good;
            if (frame_res.good) begin
              last_temperature_next = frame_res.temperature;
              last_humidity_next    = frame_res.humidity;
            end
          end else if (timeout_ticks == '0) begin
            // first sample of the new pulse already exceeds a zero timeout
            phase_next        = PH_IDLE;
            tick_counter_next = '0;
            done_next         = 1'b1;
            last_ok_next      = 1'b0;
          end else begin
            tick_counter_next = swhsr_pkg::CntBits'(1);
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (command) begin
          phase_next           = PH_RELEASE;
          tick_counter_next    = '0;
          low_pulse_count_next = '0;
          bit_index_next       = '0;
          frame_bits_next      = '0;
        end
      end
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks   <= swhsr_pkg::TimeoutReset;
      release_ticks   <= swhsr_pkg::ReleaseReset;
      start_low_ticks <= swhsr_pkg::StartLowReset;
      settle_ticks    <= swhsr_pkg::SettleReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swhsr_pkg::CfgTimeout:  timeout_ticks   <= cfg_data;
        swhsr_pkg::CfgRelease:  release_ticks   <= cfg_data[swhsr_pkg::DurBits-1:0];
        swhsr_pkg::CfgStartLow: start_low_ticks <= cfg_data[swhsr_pkg::DurBits-1:0];
        default:                settle_ticks    <= cfg_data[swhsr_pkg::DurBits-1:0];
      endcase
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      tick_counter     <= '0;
      low_pulse_count  <= '0;
      bit_index        <= '0;
      frame_bits       <= '0;
      last_ok          <= 1'b0;
      last_temperature <= '0;
      last_humidity    <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (s_fire) begin
        phase            <= phase_next;
        tick_counter     <= tick_counter_next;
        low_pulse_count  <= low_pulse_count_next;
        bit_index        <= bit_index_next;
        frame_bits       <= frame_bits_next;
        last_ok          <= last_ok_next;
        last_temperature <= last_temperature_next;
        last_humidity    <= last_humidity_next;
        m_tvalid         <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tdata <= {4'h0, last_humidity_next, last_temperature_next, last_ok_next, done_next,
                  (phase_next != PH_IDLE), (phase_next == PH_START_LOW)};
    end
  end

  // checks
  a_drive_needs_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> m_tdata[1])
    else $error("drive_low reported outside a read");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> !m_tdata[1])
    else $error("read reported done while still busy");

  // a completed frame leaves the index at the frame length until the next start
  a_bit_index_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= swhsr_pkg::FrameCount)
    else $error("bit index ran past the frame");

  a_done_from_measure: assert property (@(posedge clk) disable iff (rst)
    (s_fire && done_next) |=> (phase == PH_IDLE && tick_counter == '0))
    else $error("finished read left the sequencer active");

endmodule

[rtl/swhsr_frame_check.sv]
// ----------------------------------------------------------------------------
// swhsr_frame_check
// Checksum test and sign/magnitude decode of one received 40-bit frame.
// ----------------------------------------------------------------------------
module swhsr_frame_check (
  input  logic [swhsr_pkg::FrameBits-1:0] frame,
  output swhsr_pkg::frame_res_t           res
);

  logic [7:0] b0, b1, b2, b3, b4;
  logic [7:0] sum;
  logic [swhsr_pkg::WordBits-1:0] mag;

  assign b0  = frame[39:32];
  assign b1  = frame[31:24];
  assign b2  = frame[23:16];
  assign b3  = frame[15:8];
  assign b4  = frame[7:0];
  assign sum = b0 + b1 + b2 + b3;   // wraps mod 256
  assign mag = {b2 & swhsr_pkg::MagMask, b3};

  always_comb begin
    res.good        = (b4 == sum);
    res.temperature = ((b2 & swhsr_pkg::SignMask) != 8'h00) ? -$signed(mag) : $signed(mag);
    res.humidity    = {b0, b1};
  end

endmodule

[tb/sv/sensor_reader_monitor.sv]
// ----------------------------------------------------------------------------
// sensor_reader_monitor
// Watches the tick stream, the status stream and the register port of the
// sensor reader, predicts one status item per tick and compares it.
// ----------------------------------------------------------------------------
module sensor_reader_monitor
  import swhsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [0] command, [1] line_level
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [39:0]           m_tdata,   // [0] drive_low, [1] busy_res,
                                           // [2] done_res, [3] read_ok,
                                           // [19:4] temperature,
                                           // [35:20] humidity
  input  logic                  cfg_we,
  input  logic [CfgIdxBits-1:0] cfg_index,
  input  logic [CntBits-1:0]    cfg_data,
  output int                    errors,
  output int                    pending,
  output logic                  rd_busy,   // predicted: read in progress
  output logic                  rd_timing  // predicted: release/start/settle
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RELEASE,
    ST_START_LOW,
    ST_SETTLE,
    ST_RESP_LOW,
    ST_RESP_HIGH,
    ST_BIT_LOW,
    ST_BIT_HIGH
  } rd_phase_e;

  typedef struct packed {
    logic                drive_low;
    logic                busy;
    logic                done;
    logic                ok;
    logic [WordBits-1:0] temp;
    logic [WordBits-1:0] hum;
  } status_t;

  // register copies
  logic [CntBits-1:0] cfg_timeout;
  logic [DurBits-1:0] cfg_release;
  logic [DurBits-1:0] cfg_start_low;
  logic [DurBits-1:0] cfg_settle;

  // reader state
  rd_phase_e             ph;
  logic [CntBits-1:0]    cnt;
  logic [CntBits-1:0]    low_cnt;
  logic [BitIdxBits-1:0] bit_idx;
  logic [FrameBits-1:0]  frame;
  logic                  last_ok;
  logic [WordBits-1:0]   last_temp;
  logic [WordBits-1:0]   last_hum;
  logic                  done_flag;

  status_t status_due[$];

  initial begin
    errors    = 0;
    pending   = 0;
    rd_busy   = 1'b0;
    rd_timing = 1'b0;
  end

  task automatic end_read(input logic good);
    ph        = ST_IDLE;
    cnt       = '0;
    done_flag = 1'b1;
    last_ok   = good;
  endtask

  task automatic timed_step(input logic [DurBits-1:0] dur, input rd_phase_e nxt);
    if (cnt < CntMax) cnt = cnt + 1'b1;
    if (cnt >= CntBits'(dur) || cnt >= CntMax) begin
      ph  = nxt;
      cnt = '0;
    end
  endtask

  // one tick of the reader; the status reflects the state after the update
  task automatic step_reader(input logic cmd, input logic line, output status_t res);
    logic                want;
    logic                stop;
    logic [7:0]          b0, b1, b2, b3, b4;
    logic [7:0]          sum;
    logic [WordBits-1:0] mag;
    done_flag = 1'b0;
    stop      = 1'b0;
    case (ph)
      ST_RELEASE:   timed_step(cfg_release, ST_START_LOW);
      ST_START_LOW: timed_step(cfg_start_low, ST_SETTLE);
      ST_SETTLE:    timed_step(cfg_settle, ST_RESP_LOW);
      ST_RESP_LOW, ST_RESP_HIGH, ST_BIT_LOW, ST_BIT_HIGH: begin
        // a level change closes the pulse and opens the next one on the
        // same sample, so at most two passes
        for (int pass_i = 0; pass_i < 2 && !stop; pass_i++) begin
          want = (ph == ST_RESP_HIGH || ph == ST_BIT_HIGH);
          if (line == want) begin
            if (cnt >= cfg_timeout || cnt >= CntMax) end_read(1'b0);
            else cnt = cnt + 1'b1;
            stop = 1'b1;
          end else begin
            case (ph)
              ST_RESP_LOW:  ph = ST_RESP_HIGH;
              ST_RESP_HIGH: ph = ST_BIT_LOW;
              ST_BIT_LOW: begin
                low_cnt = cnt;
                ph      = ST_BIT_HIGH;
              end
              default: begin
                frame   = {frame[FrameBits-2:0], (cnt > low_cnt)};
                bit_idx = bit_idx + 1'b1;
                if (bit_idx >= FrameCount) begin
                  b0  = frame[39:32];
                  b1  = frame[31:24];
                  b2  = frame[23:16];
                  b3  = frame[15:8];
                  b4  = frame[7:0];
                  sum = b0 + b1 + b2 + b3;
                  if (b4 == sum) begin
                    mag = {b2 & MagMask, b3};
                    if ((b2 & SignMask) != 8'h00) mag = -mag;
                    last_temp = mag;
                    last_hum  = {b0, b1};
                    end_read(1'b1);
                  end else begin
                    end_read(1'b0);
                  end
                  stop = 1'b1;
                end else begin
                  ph = ST_BIT_LOW;
                end
              end
            endcase
            if (!stop) cnt = '0;
          end
        end
      end
      default: begin
        ph = ST_IDLE;
        if (cmd) begin
          ph      = ST_RELEASE;
          cnt     = '0;
          low_cnt = '0;
          bit_idx = '0;
          frame   = '0;
        end
      end
    endcase
    res.drive_low = (ph == ST_START_LOW);
    res.busy      = (ph != ST_IDLE);
    res.done      = done_flag;
    res.ok        = last_ok;
    res.temp      = last_temp;
    res.hum       = last_hum;
  endtask

  task automatic cmp_field(input string name, input int unsigned exp_v,
                           input int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
               $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : watch
    status_t due;
    if (rst) begin
      cfg_timeout   = TimeoutReset;
      cfg_release   = ReleaseReset;
      cfg_start_low = StartLowReset;
      cfg_settle    = SettleReset;
      ph            = ST_IDLE;
      cnt           = '0;
      low_cnt       = '0;
      bit_idx       = '0;
      frame         = '0;
      last_ok       = 1'b0;
      last_temp     = '0;
      last_hum      = '0;
      done_flag     = 1'b0;
      status_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgTimeout:  cfg_timeout   = cfg_data;
          CfgRelease:  cfg_release   = cfg_data[DurBits-1:0];
          CfgStartLow: cfg_start_low = cfg_data[DurBits-1:0];
          CfgSettle:   cfg_settle    = cfg_data[DurBits-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        step_reader(s_tdata[0], s_tdata[1], due);
        status_due.push_back(due);
      end
      if (m_tvalid && m_tready) begin
        if (status_due.size() == 0) begin
          errors++;
          $display("%0t: status item with nothing expected, actual 0x%h",
                   $time, m_tdata);
        end else begin
          due = status_due.pop_front();
          cmp_field("drive_low",   due.drive_low, m_tdata[0]);
          cmp_field("busy_res",    due.busy,      m_tdata[1]);
          cmp_field("done_res",    due.done,      m_tdata[2]);
          cmp_field("read_ok",     due.ok,        m_tdata[3]);
          cmp_field("temperature", due.temp,      m_tdata[19:4]);
          cmp_field("humidity",    due.hum,       m_tdata[35:20]);
          cmp_field("padding",     0,             m_tdata[39:36]);
        end
      end
    end
    pending   <= status_due.size();
    rd_busy   <= (ph != ST_IDLE);
    rd_timing <= (ph == ST_RELEASE || ph == ST_START_LOW || ph == ST_SETTLE);
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the single-wire humidity sensor reader: plays sensor frames
// tick by tick on the line, with stalls on both streams and register changes
// between phases; the monitor beside the block does all the checking.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import swhsr_pkg::*;

  // cycles with no item moving on either stream before the run is abandoned;
  // the slowest correct stretch is a stall burst plus a register update
  localparam int unsigned QuietLimit = 1000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;   // [0] command, [1] line_level
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [39:0]           m_tdata;          // [0] drive_low, [1] busy_res,
                                           // [2] done_res, [3] read_ok,
                                           // [19:4] temperature,
                                           // [35:20] humidity
  logic                  cfg_we    = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index = CfgTimeout;
  logic [CntBits-1:0]    cfg_data  = '0;

  int   errors;
  int   pending;
  logic rd_busy;
  logic rd_timing;

  // timeout as last written, so the frame player keeps its pulses legal
  logic [CntBits-1:0] cur_timeout = TimeoutReset;
  bit                 idle_on     = 1'b1;
  logic               tgl         = 1'b0;
  int unsigned        stall_left  = 0;
  int unsigned        quiet       = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  single_wire_humidity_sensor_reader_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sensor_reader_monitor u_mon (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .rd_busy   (rd_busy),
    .rd_timing (rd_timing)
  );

  // Status sink: random bursts of back-pressure while idle_on.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: a long stretch with nothing accepted on either side ends it.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is
  // taken. tvalid stays high so back-to-back items need no extra edge; any
  // caller that stops sending lowers it on that same falling edge.
  task automatic send_item(input logic cmd, input logic line);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, line, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // start commands during a read must be ignored, so throw them in at random
  function automatic logic busy_cmd();
    return rd_busy ? 1'($urandom_range(0, 1)) : 1'b0;
  endfunction

  // sender stops until every status item owed has come back
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // end any read in flight: with a short timeout a steady line times it out,
  // with a long one toggling each tick runs the frame out
  task automatic finish_read();
    while (rd_busy) begin
      if (cur_timeout > CntBits'(8)) tgl = ~tgl;
      send_item(1'b0, tgl);
    end
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_item(1'b0, 1'($urandom_range(0, 1)));
  endtask

  // registers change only with the reader idle and nothing owed
  task automatic set_config(input logic [CntBits-1:0] tmo, input logic [DurBits-1:0] rel,
                            input logic [DurBits-1:0] slo, input logic [DurBits-1:0] stl);
    finish_read();
    hold_until_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CfgTimeout;
    cfg_data  <= tmo;
    @(negedge clk);
    cfg_index <= CfgRelease;
    cfg_data  <= CntBits'(rel);
    @(negedge clk);
    cfg_index <= CfgStartLow;
    cfg_data  <= CntBits'(slo);
    @(negedge clk);
    cfg_index <= CfgSettle;
    cfg_data  <= CntBits'(stl);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_timeout = tmo;
  endtask

  // one pulse of n samples at a level; a stretched pulse overruns the
  // timeout by one sample. Stops as soon as the read has ended.
  task automatic line_pulse(input logic level, input int n, input bit stretch);
    int len;
    len = stretch ? int'(cur_timeout) + 1 : n;
    repeat (len) if (rd_busy) send_item(busy_cmd(), level);
  endtask

  function automatic logic [39:0] make_frame(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3,
                                             input bit good);
    logic [7:0] sum;
    sum = b0 + b1 + b2 + b3;
    if (!good) sum = sum ^ 8'($urandom_range(1, 255));
    return {b0, b1, b2, b3, sum};
  endfunction

  // Plays a whole read as the sensor would: start command, the timed phases
  // with junk on the line, response low (may be empty) and high, 40 bit
  // pairs, then the low sample that closes the last high pulse.
  // Pulses are at most two samples long.
  // fail_at picks a pulse to stretch past the timeout: 0 response low,
  // 1 response high, 2+2k / 3+2k bit k low / high; -1 for none.
  task automatic do_read(input logic [39:0] frm, input int fail_at);
    int m;
    int lo;
    int hi;
    m = (cur_timeout < CntBits'(2)) ? int'(cur_timeout) : 2;
    if (m < 1) m = 1;
    send_item(1'b1, 1'($urandom_range(0, 1)));
    while (rd_timing) send_item(busy_cmd(), 1'($urandom_range(0, 1)));
    line_pulse(1'b0, $urandom_range(0, m), fail_at == 0);
    line_pulse(1'b1, $urandom_range(1, m), fail_at == 1);
    for (int k = 0; k < 40; k++) begin
      if (m < 2) begin
        lo = 1;
        hi = 1;
      end else if (frm[39-k]) begin
        lo = $urandom_range(1, m - 1);
        hi = $urandom_range(lo + 1, m);
      end else begin
        lo = $urandom_range(1, m);
        hi = $urandom_range(1, lo);
      end
      line_pulse(1'b0, lo, fail_at == 2 + 2 * k);
      line_pulse(1'b1, hi, fail_at == 3 + 2 * k);
    end
    line_pulse(1'b0, 1, 1'b0);
  endtask

  initial begin
    int pick;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed part ---
    idle_ticks(4);
    set_config(CntBits'(3), DurBits'(1), DurBits'(2), DurBits'(1));
    do_read(make_frame(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1), -1);  // most negative
    do_read(make_frame(8'h55, 8'hAA, 8'h12, 8'h34, 1'b0), -1);  // bad checksum
    // timeout in the response low, the response high and a bit high pulse
    do_read(make_frame(8'h11, 8'h22, 8'h33, 8'h44, 1'b1), 0);
    do_read(make_frame(8'h11, 8'h22, 8'h33, 8'h44, 1'b1), 1);
    do_read(make_frame(8'hFF, 8'h22, 8'h33, 8'h44, 1'b1), 3);
    idle_ticks(3);

    // shortest nonzero timeout and zero timed-phase settings, timeout in a bit low
    set_config(CntBits'(1), '0, '0, '0);
    do_read(make_frame(8'h00, 8'h00, 8'h00, 8'h00, 1'b1), 2);
    // zero timeout: the first sample at a pulse's level fails the read
    set_config('0, DurBits'(1), DurBits'(1), DurBits'(1));
    do_read(make_frame(8'h12, 8'h34, 8'h56, 8'h78, 1'b1), -1);
    // widest timeout, minus zero
    set_config(CntMax, DurBits'(2), DurBits'(1), '0);
    do_read(make_frame(8'h03, 8'hE8, 8'h80, 8'h00, 1'b1), -1);

    // --- random part: two register settings, the last one without stalls ---
    for (int ph_i = 0; ph_i < 2; ph_i++) begin
      set_config(CntBits'($urandom_range(2, 4)), DurBits'($urandom_range(0, 2)),
                 DurBits'($urandom_range(0, 2)), DurBits'($urandom_range(0, 2)));
      idle_on = (ph_i == 0);
      idle_ticks($urandom_range(0, 3));
      // a read that times out early in one of the first pulses
      pick = $urandom_range(0, 5);
      do_read(make_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         $urandom_range(0, 3) != 0), pick);
      // line noise with stray start commands
      repeat ($urandom_range(10, 20))
        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      finish_read();
    end

    // --- wind down: everything owed back, then idle cycles before the verdict ---
    finish_read();
    hold_until_drained();
    repeat (8) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/swhsr_pkg.sv
rtl/swhsr_frame_check.sv
rtl/single_wire_humidity_sensor_reader_unit.sv
tb/sv/sensor_reader_monitor.sv
tb/sv/tb.sv
